@@ sv/mhbp_pkg.sv @@
// ---------------------------------------------------------------------------
// mhbp_pkg : shared types and helpers for the mapping header bit parser
// phase codes, result kinds, parse state record and field width helpers
// ---------------------------------------------------------------------------
`default_nettype none

package mhbp_pkg;

   // parse phases of one mapping header
   typedef enum logic [3:0] {
      PH_SFLAG  = 4'd0,
      PH_SCOUNT = 4'd1,
      PH_CFLAG  = 4'd2,
      PH_STEPS  = 4'd3,
      PH_MAG    = 4'd4,
      PH_ANG    = 4'd5,
      PH_RSV    = 4'd6,
      PH_MUX    = 4'd7,
      PH_TIME   = 4'd8,
      PH_FLOOR  = 4'd9,
      PH_RES    = 4'd10
   } phase_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_SUBMAPS  = 3'd0,
      KIND_STEPS    = 3'd1,
      KIND_MAG      = 3'd2,
      KIND_ANG      = 3'd3,
      KIND_MUX      = 3'd4,
      KIND_FLOOR    = 3'd5,
      KIND_RESIDUE  = 3'd6,
      KIND_ERROR    = 3'd7
   } kind_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  bits_taken;
      logic [7:0]  field_shift;
      logic [7:0]  item_counter;
      logic [4:0]  submap_total;
      logic [8:0]  step_total;
      logic [7:0]  held_mag;
   } parse_state_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [7:0]  index;
      logic [8:0]  value;
      logic        final_res;
   } result_type;

   localparam parse_state_type STATE_RESET = '{
      phase:        PH_SFLAG,
      bits_taken:   4'd0,
      field_shift:  8'd0,
      item_counter: 8'd0,
      submap_total: 5'd1,
      step_total:   9'd0,
      held_mag:     8'd0
   };

   localparam logic [7:0] CHANNEL_COUNT_RESET = 8'd2;

   // bits needed for a channel number: ilog(channel_count - 1)
   function automatic logic [3:0] chan_bits(input logic [7:0] channel_count);
      logic [7:0] x;
      logic [3:0] n;
      x = (channel_count == 8'd0) ? 8'd0 : channel_count - 8'd1;
      n = 4'd0;
      for (int b = 0; b < 8; b++) begin
         if (x[b]) begin
            n = 4'(b + 1);
         end
      end
      return n;
   endfunction

   function automatic logic [3:0] field_width(input phase_type phase,
                                              input logic [7:0] channel_count);
      logic [3:0] w;
      case (phase)
         PH_SFLAG, PH_CFLAG: w = 4'd1;
         PH_SCOUNT, PH_MUX:  w = 4'd4;
         PH_RSV:             w = 4'd2;
         PH_MAG, PH_ANG:     w = chan_bits(channel_count);
         default:            w = 4'd8;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ sv/mapping_header_bit_parser_unit.sv @@
// ---------------------------------------------------------------------------
// mapping_header_bit_parser_unit : mapping header bit parser
// parses one mapping header of a setup packet, one bit per beat
// ---------------------------------------------------------------------------
// usage
//   req channel: one packet bit per beat in req_tdata[0], least significant
//     bit of each field first; req_tuser high marks the packet as exhausted
//     (no bit carried) and gives an error result
//   rsp channel: at most one beat per parsed field; rsp_tuser holds the kind,
//     rsp_tdata the index and value, rsp_tlast the last result of the
//     mapping or an error; the parser then restarts on the next header
//   csr port: csr_wr_en / csr_wr_data write the channel count, which sets
//     the width of the coupling channel fields
//   result timing: a result is on rsp in the cycle after the bit that completes its
//     field is accepted; most bits complete nothing and give no beat
//   throughput: one bit per cycle while req_tready is high; the parse step
//     is a single pass of logic between the state and result registers
//   stalls: req_tready drops only while a result is held and rsp_tready is
//     low; the held beat stays put until taken
//   reset: synchronous, parser back to the submap flag, channel count 2,
//     result register empty
// ---------------------------------------------------------------------------
`default_nettype none

module mapping_header_bit_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // packet bit stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] bit_req, [7:1] zero
   input  wire logic        req_tuser,   // [0] packet_end
   // parsed fields
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] index, [16:8] value, [23:17] zero
   output logic [2:0]       rsp_tuser,   // [2:0] kind
   output logic             rsp_tlast,   // final_res
   // channel count register
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   mhbp_pkg::parse_state_type state_ff;
   mhbp_pkg::parse_state_type state_in;
   mhbp_pkg::result_type      result;

   logic [7:0] channel_count_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [2:0] rsp_kind_ff;
   logic [7:0] rsp_index_ff;
   logic [8:0] rsp_value_ff;
   logic       rsp_last_ff;
   logic       req_accept;
   logic       rsp_load;

   // output register free, or being emptied this cycle
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = rsp_load;
   assign req_accept = req_tvalid && req_tready;

   // parse step: current state plus one bit
   mhbp_step u_step (
      .state_ff      (state_ff),
      .channel_count (channel_count_ff),
      .bit_req       (req_tdata[0]),
      .packet_end    (req_tuser),
      .state_in      (state_in),
      .result        (result)
   );

   // parse state advances on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhbp_pkg::STATE_RESET;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // channel count register
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= mhbp_pkg::CHANNEL_COUNT_RESET;
      end else if (csr_wr_en) begin
         channel_count_ff <= csr_wr_data;
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = req_accept && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (rsp_load && req_accept) begin
         rsp_kind_ff  <= result.kind;
         rsp_index_ff <= result.index;
         rsp_value_ff <= result.value;
         rsp_last_ff  <= result.final_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_value_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // an exhausted packet always yields an error beat on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser |=> rsp_tvalid && rsp_tlast
         && rsp_tuser == mhbp_pkg::KIND_ERROR)
      else $error("packet end did not give an error beat");

   // parser is back at the header start while its final beat is held
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> state_ff.phase == mhbp_pkg::PH_SFLAG
         && state_ff.bits_taken == 4'd0)
      else $error("parser not restarted after final beat");

   // an error beat always closes the mapping and carries a zero payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == mhbp_pkg::KIND_ERROR |-> rsp_tlast
         && rsp_tdata == 24'd0)
      else $error("error beat without last or with payload");
`endif

endmodule

`default_nettype wire

@@ sv/mhbp_step.sv @@
// ---------------------------------------------------------------------------
// mhbp_step : one-bit parse step
// takes the current parse state and one packet bit, gives the next state
// and the result (if any) caused by that bit
// ---------------------------------------------------------------------------
`default_nettype none

module mhbp_step (
   input  wire mhbp_pkg::parse_state_type state_ff,
   input  wire logic [7:0]                channel_count,
   input  wire logic                      bit_req,
   input  wire logic                      packet_end,
   output mhbp_pkg::parse_state_type      state_in,
   output mhbp_pkg::result_type           result
);

   logic [3:0] width;
   logic [3:0] taken_next;
   logic [7:0] shifted;
   logic       field_done;
   logic [7:0] v;
   logic [7:0] i;
   logic [8:0] i_plus;
   logic       mag_bad;
   logic       ang_bad;
   logic       mux_bad;
   logic       rsv_bad;
   logic       last_step;
   logic       last_chan;
   logic       last_submap;
   logic [4:0] scount_total;
   logic [8:0] steps_total;

   assign width      = mhbp_pkg::field_width(state_ff.phase, channel_count);
   assign taken_next = state_ff.bits_taken + 4'd1;
   assign shifted    = state_ff.field_shift
                     | (8'(bit_req) << state_ff.bits_taken[2:0]);
   assign field_done = (taken_next >= width);
   assign v          = shifted;
   assign i          = state_ff.item_counter;
   assign i_plus     = {1'b0, i} + 9'd1;

   assign mag_bad     = (v >= channel_count);
   assign ang_bad     = (v >= channel_count) || (v == state_ff.held_mag);
   assign mux_bad     = (v >= {3'd0, state_ff.submap_total});
   assign rsv_bad     = (v != 8'd0);
   assign last_step   = (i_plus >= state_ff.step_total);
   assign last_chan   = (i_plus >= {1'b0, channel_count});
   assign last_submap = (i_plus >= {4'd0, state_ff.submap_total});

   assign scount_total = {1'b0, v[3:0]} + 5'd1;
   assign steps_total  = {1'b0, v} + 9'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      if (packet_end) begin
         state_in = mhbp_pkg::STATE_RESET;
      end else if (!field_done) begin
         state_in.bits_taken  = taken_next;
         state_in.field_shift = shifted;
      end else begin
         state_in.bits_taken  = 4'd0;
         state_in.field_shift = 8'd0;
         case (state_ff.phase)
            mhbp_pkg::PH_SFLAG: begin
               if (v != 8'd0) begin
                  state_in.phase = mhbp_pkg::PH_SCOUNT;
               end else begin
                  state_in.submap_total = 5'd1;
                  state_in.phase        = mhbp_pkg::PH_CFLAG;
               end
            end
            mhbp_pkg::PH_SCOUNT: begin
               state_in.submap_total = scount_total;
               state_in.phase        = mhbp_pkg::PH_CFLAG;
            end
            mhbp_pkg::PH_CFLAG: begin
               if (v != 8'd0) begin
                  state_in.phase = mhbp_pkg::PH_STEPS;
               end else begin
                  state_in.step_total = 9'd0;
                  state_in.phase      = mhbp_pkg::PH_RSV;
               end
            end
            mhbp_pkg::PH_STEPS: begin
               state_in.step_total   = steps_total;
               state_in.item_counter = 8'd0;
               state_in.phase = (mhbp_pkg::chan_bits(channel_count) == 4'd0)
                              ? mhbp_pkg::PH_RSV : mhbp_pkg::PH_MAG;
            end
            mhbp_pkg::PH_MAG: begin
               if (mag_bad) begin
                  state_in = mhbp_pkg::STATE_RESET;
               end else begin
                  state_in.held_mag = v;
                  state_in.phase    = mhbp_pkg::PH_ANG;
               end
            end
            mhbp_pkg::PH_ANG: begin
               if (ang_bad) begin
                  state_in = mhbp_pkg::STATE_RESET;
               end else if (last_step) begin
                  state_in.item_counter = 8'd0;
                  state_in.phase        = mhbp_pkg::PH_RSV;
               end else begin
                  state_in.item_counter = i_plus[7:0];
                  state_in.phase        = mhbp_pkg::PH_MAG;
               end
            end
            mhbp_pkg::PH_RSV: begin
               if (rsv_bad) begin
                  state_in = mhbp_pkg::STATE_RESET;
               end else begin
                  state_in.item_counter = 8'd0;
                  state_in.phase = (state_ff.submap_total > 5'd1 && channel_count != 8'd0)
                                 ? mhbp_pkg::PH_MUX : mhbp_pkg::PH_TIME;
               end
            end
            mhbp_pkg::PH_MUX: begin
               if (mux_bad) begin
                  state_in = mhbp_pkg::STATE_RESET;
               end else if (last_chan) begin
                  state_in.item_counter = 8'd0;
                  state_in.phase        = mhbp_pkg::PH_TIME;
               end else begin
                  state_in.item_counter = i_plus[7:0];
               end
            end
            mhbp_pkg::PH_TIME: begin
               state_in.phase = mhbp_pkg::PH_FLOOR;
            end
            mhbp_pkg::PH_FLOOR: begin
               state_in.phase = mhbp_pkg::PH_RES;
            end
            mhbp_pkg::PH_RES: begin
               if (last_submap) begin
                  state_in = mhbp_pkg::STATE_RESET;
               end else begin
                  state_in.item_counter = i_plus[7:0];
                  state_in.phase        = mhbp_pkg::PH_TIME;
               end
            end
            default: begin
               state_in = mhbp_pkg::STATE_RESET;
            end
         endcase
      end
   end

   // result of this bit
   always_comb begin
      result           = '0;
      result.kind      = mhbp_pkg::KIND_ERROR;
      if (packet_end) begin
         result.valid     = 1'b1;
         result.final_res = 1'b1;
      end else if (field_done) begin
         case (state_ff.phase)
            mhbp_pkg::PH_SFLAG: begin
               result.valid = (v == 8'd0);
               result.kind  = mhbp_pkg::KIND_SUBMAPS;
               result.value = 9'd1;
            end
            mhbp_pkg::PH_SCOUNT: begin
               result.valid = 1'b1;
               result.kind  = mhbp_pkg::KIND_SUBMAPS;
               result.value = {4'd0, scount_total};
            end
            mhbp_pkg::PH_CFLAG: begin
               result.valid = (v == 8'd0);
               result.kind  = mhbp_pkg::KIND_STEPS;
            end
            mhbp_pkg::PH_STEPS: begin
               result.valid = 1'b1;
               result.kind  = mhbp_pkg::KIND_STEPS;
               result.value = steps_total;
            end
            mhbp_pkg::PH_MAG: begin
               result.valid = 1'b1;
               if (mag_bad) begin
                  result.final_res = 1'b1;
               end else begin
                  result.kind  = mhbp_pkg::KIND_MAG;
                  result.index = i;
                  result.value = {1'b0, v};
               end
            end
            mhbp_pkg::PH_ANG: begin
               result.valid = 1'b1;
               if (ang_bad) begin
                  result.final_res = 1'b1;
               end else begin
                  result.kind  = mhbp_pkg::KIND_ANG;
                  result.index = i;
                  result.value = {1'b0, v};
               end
            end
            mhbp_pkg::PH_RSV: begin
               result.valid     = rsv_bad;
               result.final_res = 1'b1;
            end
            mhbp_pkg::PH_MUX: begin
               result.valid = 1'b1;
               if (mux_bad) begin
                  result.final_res = 1'b1;
               end else begin
                  result.kind  = mhbp_pkg::KIND_MUX;
                  result.index = i;
                  result.value = {1'b0, v};
               end
            end
            mhbp_pkg::PH_FLOOR: begin
               result.valid = 1'b1;
               result.kind  = mhbp_pkg::KIND_FLOOR;
               result.index = i;
               result.value = {1'b0, v};
            end
            mhbp_pkg::PH_RES: begin
               result.valid     = 1'b1;
               result.kind      = mhbp_pkg::KIND_RESIDUE;
               result.index     = i;
               result.value     = {1'b0, v};
               result.final_res = last_submap;
            end
            default: begin
               result.valid = 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
